FILE: src/bss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bss_pkg
// Types and constants shared by the sorted-table search block.
// ----------------------------------------------------------------------------
package bss_pkg;

    localparam int FUNC_W  = 1;
    localparam int SLOT_W  = 6;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    localparam int POS_W   = 6;

    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

FILE: src/bss_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bss_ram
// Table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bss_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: src/binary_search_sorted_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_search_sorted_table
// Sorted table of signed values with a binary-search lookup.
// ----------------------------------------------------------------------------
// Load request: written the cycle it is accepted, one per cycle while idle,
//   no result. Search request: one table read per probe, at most
//   log2(TABLE_DEPTH)+1 probes, each comparing the key with the registered
//   read data; the result is registered once the output is free, and the
//   next request is taken only after the block is back in idle.
// Reset clears control state and used_count; table contents are undefined.
// ----------------------------------------------------------------------------
module binary_search_sorted_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [bss_pkg::COUNT_W-1:0]     i_cfg_wr_data,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [bss_pkg::FUNC_W-1:0]      i_func,
    input  wire logic [bss_pkg::SLOT_W-1:0]      i_slot,
    input  wire logic signed [bss_pkg::VALUE_W-1:0] i_value,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic                                 o_found,
    output logic [bss_pkg::POS_W-1:0]            o_position
);

    import bss_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    t_state r_state, n_state;

    logic [COUNT_W-1:0]        r_used_count;
    logic signed [VALUE_W-1:0] r_key;
    logic [CNT_W-1:0]          r_lo, n_lo;
    logic [CNT_W-1:0]          r_hi, n_hi;
    logic [CNT_W-1:0]          r_mid;
    logic                      r_hit, n_hit;
    logic                      r_out_valid;
    logic                      r_found;
    logic [POS_W-1:0]          r_position;

    logic                      accept;
    logic                      out_free;
    logic [31:0]               used_ext;
    logic [31:0]               count_ext;
    logic [CNT_W-1:0]          count;
    logic [31:0]               slot_ext;
    logic [31:0]               mid_ext;
    logic [CNT_W:0]            mid_sum;
    logic [CNT_W-1:0]          mid;
    logic signed [VALUE_W-1:0] entry;
    logic                      key_gt;
    logic                      key_lt;
    logic                      ram_we;
    logic                      ram_re;
    logic [VALUE_W-1:0]        ram_rdata;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != ST_IDLE);

    assign used_ext  = 32'(r_used_count);
    assign count_ext = (used_ext > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : used_ext;
    assign count     = count_ext[CNT_W-1:0];
    assign slot_ext  = 32'(i_slot);
    assign mid_ext   = 32'(r_mid);

    assign entry  = $signed(ram_rdata);
    assign key_gt = r_key > entry;
    assign key_lt = r_key < entry;

    // midpoint of [n_lo, n_hi), rounded down
    assign mid_sum = {1'b0, n_lo} + {1'b0, n_hi} - (CNT_W+1)'(1);
    assign mid     = mid_sum[CNT_W:1];

    assign ram_we = accept && (i_func == FUNC_LOAD) && (slot_ext < 32'(TABLE_DEPTH));

    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_hit   = r_hit;
        ram_re  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_lo  = '0;
                n_hi  = count;
                n_hit = 1'b0;
                if (accept && (i_func == FUNC_SEARCH)) begin
                    if (count != '0) begin
                        ram_re  = 1'b1;
                        n_state = ST_SEARCH;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SEARCH: begin
                if (key_gt) begin
                    n_lo = r_mid + CNT_W'(1);
                end
                if (key_lt) begin
                    n_hi = r_mid;
                end
                if (!key_gt && !key_lt) begin
                    n_hit   = 1'b1;
                    n_state = ST_DONE;
                end else if (n_lo >= n_hi) begin
                    n_state = ST_DONE;
                end else begin
                    ram_re = 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_count <= '0;
        end else if (i_cfg_wr_en) begin
            r_used_count <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= i_value;
        end
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_hit <= n_hit;
        if (ram_re) begin
            r_mid <= mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_found    <= r_hit;
            r_position <= r_hit ? mid_ext[POS_W-1:0] : '0;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_found    = r_found;
    assign o_position = r_position;

    bss_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IDX_W),
        .DATA_W (VALUE_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot_ext[IDX_W-1:0]),
        .i_wdata (i_value),
        .i_re    (ram_re),
        .i_raddr (mid[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted-table search block: loads ascending
// tables (at times overwriting entries out of order), runs keyed searches over
// varied used_count settings and compares every result against an in-bench
// binary-search predictor, under random request gaps and result stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import bss_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int SETTLE       = 16;
    localparam int WDOG_LIMIT   = 4000;
    localparam int ITEM_TARGET  = 400;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_search_result;

    class search_scoreboard;
        logic signed [VALUE_W-1:0] entries [TABLE_DEPTH];
        logic [COUNT_W-1:0]        used_count;
        t_search_result            expected_q [$];
        int                        errors;

        function new();
            used_count = '0;
            errors     = 0;
            foreach (entries[i]) entries[i] = '0;
        endfunction

        function void set_count(logic [COUNT_W-1:0] c);
            used_count = c;
        endfunction

        function t_search_result predict_search(logic signed [VALUE_W-1:0] key);
            t_search_result r;
            int lo, hi, mid;
            r  = '0;
            lo = 0;
            hi = (used_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(used_count);
            while (lo < hi && !r.found) begin
                mid = (lo + hi - 1) / 2;
                if (key > entries[mid]) begin
                    lo = mid + 1;
                end else if (key < entries[mid]) begin
                    hi = mid;
                end else begin
                    r.found    = 1'b1;
                    r.position = mid[POS_W-1:0];
                end
            end
            return r;
        endfunction

        function void note_request(logic [FUNC_W-1:0] func, logic [SLOT_W-1:0] slot,
                                   logic signed [VALUE_W-1:0] value);
            if (func == FUNC_LOAD) begin
                entries[slot] = value;
            end else begin
                expected_q.push_back(predict_search(value));
            end
        endfunction

        function void check_result(logic found, logic [POS_W-1:0] position);
            t_search_result exp_r;
            if (expected_q.size() == 0) begin
                $error("result with no search pending: found %0d position %0d",
                       found, position);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (found !== exp_r.found) begin
                    $error("found: expected %0d, actual %0d", exp_r.found, found);
                    errors++;
                end
                if (position !== exp_r.position) begin
                    $error("position: expected %0d, actual %0d", exp_r.position, position);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_wr_en;
    logic [COUNT_W-1:0]        i_cfg_wr_data;
    logic                      i_valid;
    logic                      o_stall;
    logic [FUNC_W-1:0]         i_func;
    logic [SLOT_W-1:0]         i_slot;
    logic signed [VALUE_W-1:0] i_value;
    logic                      o_valid;
    logic                      i_stall;
    logic                      o_found;
    logic [POS_W-1:0]          o_position;

    search_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int item_count;
    int quiet_cycles;

    binary_search_sorted_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_func(i_func),
        .i_slot(i_slot),
        .i_value(i_value),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_found(o_found),
        .o_position(o_position)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_found, o_position);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(logic [FUNC_W-1:0] func, logic [SLOT_W-1:0] slot,
                                logic signed [VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= func;
        i_slot  <= slot;
        i_value <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(func, slot, value);
        item_count++;
        @(negedge i_clk);
    endtask

    task automatic search(logic signed [VALUE_W-1:0] key);
        send_request(FUNC_SEARCH, SLOT_W'($urandom_range(TABLE_DEPTH - 1)), key);
    endtask

    task automatic load(int slot, logic signed [VALUE_W-1:0] value);
        send_request(FUNC_LOAD, SLOT_W'(slot), value);
    endtask

    // Drain all searches, let the block settle, then write used_count.
    task automatic write_count(int c);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= COUNT_W'(c);
        sb.set_count(COUNT_W'(c));
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_phase(int c);
        int vals [$];
        int n, n_search, pick;
        bit noisy;
        logic signed [VALUE_W-1:0] key;
        n = (c > TABLE_DEPTH) ? TABLE_DEPTH : c;
        write_count(c);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0) begin
                vals.push_back($urandom_range(20) - 10);
            end else begin
                vals.push_back(int'($urandom));
            end
        end
        if (n > 0 && $urandom_range(2) == 0) vals[0] = 32'sh8000_0000;
        if (n > 1 && $urandom_range(2) == 0) vals[n-1] = 32'sh7fff_ffff;
        vals.sort();
        for (int i = 0; i < n; i++) load(i, vals[i]);
        noisy    = ($urandom_range(3) == 0);
        n_search = $urandom_range(8, 16);
        for (int i = 0; i < n_search; i++) begin
            if (noisy && $urandom_range(99) < 15) begin
                load($urandom_range(TABLE_DEPTH - 1), $urandom);
            end else begin
                pick = $urandom_range(99);
                if (n > 0 && pick < 70) begin
                    key = vals[$urandom_range(n - 1)];
                end else if (n > 0 && pick < 85) begin
                    key = vals[$urandom_range(n - 1)] + ($urandom_range(1) ? 1 : -1);
                end else begin
                    key = $urandom;
                end
                search(key);
            end
        end
    endtask

    initial begin
        int forced_counts [5] = '{64, 127, 0, 1, 65};
        int phase_idx;
        int c;
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        item_count     = 0;
        quiet_cycles   = 0;
        phase_idx      = 0;
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        i_valid        = 1'b0;
        i_func         = FUNC_LOAD;
        i_slot         = '0;
        i_value        = '0;
        i_stall        = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty range, extremes, absent keys, unsorted probe path
        search(0);
        load(0, 32'sh8000_0000);
        load(1, -5);
        load(2, 7);
        load(3, 32'sh7fff_ffff);
        load(63, 5);
        write_count(4);
        search(32'sh8000_0000);
        search(32'sh7fff_ffff);
        search(-5);
        search(7);
        search(0);
        search(-6);
        search(8);
        search(32'sh7fff_fffe);
        load(1, 100);
        search(100);
        search(7);
        write_count(1);
        search(32'sh8000_0000);
        search(3);

        for (int g = 0; g < 3; g++) begin
            case (g)
                0: begin
                    send_idle_pct  = 10;
                    recv_stall_pct = 70;
                end
                1: begin
                    send_idle_pct  = 70;
                    recv_stall_pct = 10;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            while (item_count < ITEM_TARGET * (g + 1) / 3) begin
                if (phase_idx < 5) begin
                    c = forced_counts[phase_idx];
                end else begin
                    case ($urandom_range(9))
                        0: c = 0;
                        1: c = $urandom_range(65, 127);
                        2: c = TABLE_DEPTH;
                        default: c = $urandom_range(1, 16);
                    endcase
                end
                phase_idx++;
                run_phase(c);
            end
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d search results never arrived", sb.pending());
        end
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/bss_pkg.sv
src/bss_ram.sv
src/binary_search_sorted_table.sv
tb/sv/tb_top.sv
